[rtl/assert_macros.svh]
// Assertion macros used by the transcoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/u8u16_pkg.sv]
// Package with the beat types, result kinds and Unicode constants of the transcoder.
package u8u16_pkg;

   typedef enum logic [1:0] {
      KIND_UNIT      = 2'd0,
      KIND_END       = 2'd1,
      KIND_MALFORMED = 2'd2,
      KIND_OVERFLOW  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [15:0] code_unit;
      kind_type    kind;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [15:0] code_unit;
      kind_type    kind;
   } slot_type;

   localparam int CP_W = 21;

   localparam logic [CP_W-1:0] MIN_TWO_BYTE   = 21'h000080;
   localparam logic [CP_W-1:0] MIN_THREE_BYTE = 21'h000800;
   localparam logic [CP_W-1:0] MIN_FOUR_BYTE  = 21'h010000;
   localparam logic [CP_W-1:0] MAX_CODE_POINT = 21'h10FFFF;
   localparam logic [CP_W-1:0] PLANE_OFFSET   = 21'h010000;
   localparam logic [15:0]     HIGH_SURR_BASE = 16'hD800;
   localparam logic [15:0]     LOW_SURR_BASE  = 16'hDC00;

endpackage

[rtl/utf8_to_utf16_transcoder_unit.sv]
// Top level of the UTF-8 to UTF-16 transcoder: byte decoder and result queue.
//
// The block takes one UTF-8 byte per beat and decodes it in a single pass of
// logic into a three-entry result register, which drains one result per beat on
// the rsp channel. A byte is accepted every cycle while it causes at most one
// result and rsp_ready is high; a byte that completes a supplementary character
// (two surrogate units) or ends the string after a character holds off the next
// byte until its extra results have drained through the single result port.
// A string that decodes cleanly closes with an end result; a malformed byte, a
// truncated sequence or more than MAX_UNITS code units gives one error result,
// after which bytes are dropped up to and including the end-of-string byte.
`include "assert_macros.svh"

module utf8_to_utf16_transcoder_unit
   import u8u16_pkg::*;
#(
   parameter int MAX_UNITS = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int UW = $clog2(MAX_UNITS + 1);

   // decoder state
   logic [CP_W-1:0] partial_ff, partial_in;
   logic [1:0]      expect_ff, expect_in;
   logic [2:0]      seq_len_ff, seq_len_in;
   logic [UW-1:0]   units_ff, units_in;
   logic            failed_ff, failed_in;

   // result queue
   slot_type        slot_ff [3];
   slot_type        slot_in [3];
   logic [1:0]      count_ff, count_in;

   slot_type        new_slot [3];
   logic [1:0]      new_count;

   logic            req_fire, rsp_fire;
   logic [7:0]      b;
   logic            last;
   logic [CP_W-1:0] shifted;
   logic [CP_W-1:0] cp;
   logic [CP_W-1:0] cp_off;
   logic            have_cp;
   logic            bad;
   logic            need_pair;
   logic            overflow;
   logic [UW:0]     units_sum;

   assign req_ready = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_fire  = rsp_valid && rsp_ready;

   assign rsp_data.code_unit   = slot_ff[0].code_unit;
   assign rsp_data.kind        = slot_ff[0].kind;
   assign rsp_data.last_of_run = (count_ff == 2'd1);

   assign b    = req_data.text_byte;
   assign last = req_data.end_of_string;

   assign shifted   = {partial_ff[CP_W-7:0], b[5:0]};
   assign cp_off    = cp - PLANE_OFFSET;
   assign need_pair = (cp[CP_W-1:16] != '0);
   assign units_sum = {1'b0, units_ff} + (need_pair ? (UW+1)'(2) : (UW+1)'(1));
   assign overflow  = have_cp && (units_sum > (UW+1)'(MAX_UNITS));

   // Code point assembly and validity checks for one byte.
   always_comb begin
      have_cp = 1'b0;
      cp      = '0;
      bad     = 1'b0;
      if (expect_ff == 2'd0) begin
         if (!b[7]) begin
            cp      = {13'd0, b};
            have_cp = 1'b1;
         end else if ((b[7:5] != 3'b110) && (b[7:4] != 4'b1110) && (b[7:3] != 5'b11110)) begin
            bad = 1'b1;
         end
      end else if (b[7:6] != 2'b10) begin
         bad = 1'b1;
      end else if (expect_ff == 2'd1) begin
         case (seq_len_ff)
            3'd2:    bad = (shifted < MIN_TWO_BYTE);
            3'd3:    bad = (shifted < MIN_THREE_BYTE);
            default: bad = (shifted < MIN_FOUR_BYTE) || (shifted > MAX_CODE_POINT);
         endcase
         if (!bad) begin
            cp      = shifted;
            have_cp = 1'b1;
         end
      end
   end

   // Next decoder state and the results this byte produces.
   always_comb begin
      partial_in = partial_ff;
      expect_in  = expect_ff;
      seq_len_in = seq_len_ff;
      units_in   = units_ff;
      failed_in  = failed_ff;
      new_count  = 2'd0;
      for (int i = 0; i < 3; i++) begin
         new_slot[i] = '{code_unit: 16'd0, kind: KIND_UNIT};
      end

      if (failed_ff) begin
         if (last) begin
            failed_in = 1'b0;
            units_in  = '0;
         end
      end else begin
         if (expect_ff == 2'd0) begin
            if (b[7:5] == 3'b110) begin
               partial_in = {16'd0, b[4:0]};
               expect_in  = 2'd1;
               seq_len_in = 3'd2;
            end else if (b[7:4] == 4'b1110) begin
               partial_in = {17'd0, b[3:0]};
               expect_in  = 2'd2;
               seq_len_in = 3'd3;
            end else if (b[7:3] == 5'b11110) begin
               partial_in = {18'd0, b[2:0]};
               expect_in  = 2'd3;
               seq_len_in = 3'd4;
            end
         end else begin
            partial_in = shifted;
            expect_in  = expect_ff - 2'd1;
            if (expect_ff == 2'd1) begin
               partial_in = '0;
               seq_len_in = 3'd0;
            end
         end

         if (bad || overflow) begin
            new_slot[0].kind = bad ? KIND_MALFORMED : KIND_OVERFLOW;
            new_count        = 2'd1;
            partial_in       = '0;
            expect_in        = 2'd0;
            seq_len_in       = 3'd0;
            failed_in        = 1'b1;
         end else if (have_cp) begin
            if (!need_pair) begin
               new_slot[0].code_unit = cp[15:0];
               new_count             = 2'd1;
            end else begin
               new_slot[0].code_unit = HIGH_SURR_BASE + {6'd0, cp_off[19:10]};
               new_slot[1].code_unit = LOW_SURR_BASE + {6'd0, cp_off[9:0]};
               new_count             = 2'd2;
            end
            units_in = units_sum[UW-1:0];
         end

         if (last) begin
            // Only a string with no error, this byte included, gets a closing result.
            if (!failed_in) begin
               new_slot[new_count].kind = (expect_in != 2'd0) ? KIND_MALFORMED : KIND_END;
               new_count                = new_count + 2'd1;
            end
            partial_in = '0;
            expect_in  = 2'd0;
            seq_len_in = 3'd0;
            units_in   = '0;
            failed_in  = 1'b0;
         end
      end
   end

   // Result queue: load a fresh group on an accepted byte, else shift on a taken beat.
   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (req_fire) begin
         slot_in  = new_slot;
         count_in = new_count;
      end else if (rsp_fire) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         count_in   = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         expect_ff  <= 2'd0;
         seq_len_ff <= 3'd0;
         units_ff   <= '0;
         failed_ff  <= 1'b0;
         count_ff   <= 2'd0;
      end else begin
         if (req_fire) begin
            partial_ff <= partial_in;
            expect_ff  <= expect_in;
            seq_len_ff <= seq_len_in;
            units_ff   <= units_in;
            failed_ff  <= failed_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   `ASSERT_ALWAYS(a_units_bound, units_ff <= UW'(MAX_UNITS), "unit count above limit")
   `ASSERT_IMPLIES(a_failed_idle, failed_ff,
      (expect_ff == 2'd0) && (seq_len_ff == 3'd0) && (partial_ff == '0),
      "sequence state left after an error")
   `ASSERT_IMPLIES(a_error_last, rsp_valid && (rsp_data.kind != KIND_UNIT),
      rsp_data.last_of_run, "end or error result not last of its run")
   `ASSERT_NEXT(a_drain_step, rsp_fire && (count_ff > 2'd1),
      count_ff == $past(count_ff) - 2'd1, "result queue did not drain by one")

endmodule

[tb/sv/tb_utf8_to_utf16_transcoder_unit.sv]
// Self-checking testbench for the UTF-8 to UTF-16 transcoder unit.
`timescale 1ns / 100ps

module tb_utf8_to_utf16_transcoder_unit
   import u8u16_pkg::*;
();

   localparam int          MAX_UNITS     = 256;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int          SETTLE_CYCLES = 16;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned beats_sent    = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count   = 0;

   // Decoder state of the predictor.
   logic [CP_W-1:0] acc_cp     = '0;
   logic [1:0]      conts_left = '0;
   logic [2:0]      seq_len    = '0;
   int unsigned     units_out  = 0;
   bit              str_failed = 1'b0;

   rsp_type expected_utf16_q[$];

   utf8_to_utf16_transcoder_unit #(
      .MAX_UNITS(MAX_UNITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic void clear_string_state();
      acc_cp     = '0;
      conts_left = '0;
      seq_len    = '0;
      units_out  = 0;
      str_failed = 1'b0;
   endfunction

   function automatic void expect_result(input logic [15:0] unit, input kind_type kind);
      rsp_type item;
      item.code_unit   = unit;
      item.kind        = kind;
      item.last_of_run = 1'b0;
      expected_utf16_q.push_back(item);
   endfunction

   function automatic void fail_string(input kind_type kind);
      expect_result(16'h0000, kind);
      acc_cp     = '0;
      conts_left = '0;
      seq_len    = '0;
      str_failed = 1'b1;
   endfunction

   // Works out the results that one accepted byte causes.
   function automatic void predict_utf16(input req_type beat);
      logic [7:0]      b;
      logic [CP_W-1:0] cp;
      logic [CP_W-1:0] value;
      logic [CP_W-1:0] ofs;
      bit              have_cp;
      bit              bad;
      int unsigned     need;
      int              first;
      rsp_type         tail;
      b       = beat.text_byte;
      cp      = '0;
      have_cp = 1'b0;
      first   = expected_utf16_q.size();
      if (str_failed) begin
         if (beat.end_of_string) begin
            clear_string_state();
         end
         return;
      end
      if (conts_left == 2'd0) begin
         if (b[7] == 1'b0) begin
            cp      = {13'd0, b};
            have_cp = 1'b1;
         end else if (b[7:5] == 3'b110) begin
            acc_cp     = {16'd0, b[4:0]};
            conts_left = 2'd1;
            seq_len    = 3'd2;
         end else if (b[7:4] == 4'b1110) begin
            acc_cp     = {17'd0, b[3:0]};
            conts_left = 2'd2;
            seq_len    = 3'd3;
         end else if (b[7:3] == 5'b11110) begin
            acc_cp     = {18'd0, b[2:0]};
            conts_left = 2'd3;
            seq_len    = 3'd4;
         end else begin
            fail_string(KIND_MALFORMED);
         end
      end else if (b[7:6] != 2'b10) begin
         fail_string(KIND_MALFORMED);
      end else begin
         acc_cp     = {acc_cp[CP_W-7:0], b[5:0]};
         conts_left = conts_left - 2'd1;
         if (conts_left == 2'd0) begin
            value = acc_cp;
            case (seq_len)
               3'd2: begin
                  bad = value < MIN_TWO_BYTE;
               end
               3'd3: begin
                  bad = value < MIN_THREE_BYTE;
               end
               default: begin
                  bad = (value < MIN_FOUR_BYTE) || (value > MAX_CODE_POINT);
               end
            endcase
            acc_cp  = '0;
            seq_len = '0;
            if (bad) begin
               fail_string(KIND_MALFORMED);
            end else begin
               cp      = value;
               have_cp = 1'b1;
            end
         end
      end
      if (have_cp) begin
         need = (cp < PLANE_OFFSET) ? 1 : 2;
         if (units_out + need > MAX_UNITS) begin
            fail_string(KIND_OVERFLOW);
         end else if (need == 1) begin
            expect_result(cp[15:0], KIND_UNIT);
            units_out += 1;
         end else begin
            ofs = cp - PLANE_OFFSET;
            expect_result(HIGH_SURR_BASE + {6'd0, ofs[19:10]}, KIND_UNIT);
            expect_result(LOW_SURR_BASE + {6'd0, ofs[9:0]}, KIND_UNIT);
            units_out += 2;
         end
      end
      if (beat.end_of_string) begin
         if (!str_failed) begin
            expect_result(16'h0000, (conts_left != 2'd0) ? KIND_MALFORMED : KIND_END);
         end
         clear_string_state();
      end
      if (expected_utf16_q.size() > first) begin
         tail = expected_utf16_q[expected_utf16_q.size() - 1];
         tail.last_of_run = 1'b1;
         expected_utf16_q[expected_utf16_q.size() - 1] = tail;
      end
   endfunction

   // Predicting and checking share one process so that their order within a step is fixed.
   always @(posedge clock) begin : monitor_blk
      rsp_type want;
      if (reset) begin
         clear_string_state();
      end else begin
         if (req_valid && req_ready) begin
            predict_utf16(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_utf16_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected result: unit %h kind %0d last %b",
                           rsp_data.code_unit, rsp_data.kind, rsp_data.last_of_run);
               end
            end else begin
               want = expected_utf16_q.pop_front();
               if (rsp_data.code_unit !== want.code_unit || rsp_data.kind !== want.kind ||
                   rsp_data.last_of_run !== want.last_of_run) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch: expected %h kind %0d last %b, got %h kind %0d last %b",
                              want.code_unit, want.kind, want.last_of_run,
                              rsp_data.code_unit, rsp_data.kind, rsp_data.last_of_run);
                  end
               end
            end
         end
      end
   end

   task automatic send_beat(input logic [7:0] text, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{text_byte: text, end_of_string: eos};
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   task automatic send_sequence(input logic [7:0] seq[$], input logic eos);
      foreach (seq[i]) begin
         send_beat(seq[i], eos && (i == seq.size() - 1));
      end
   endtask

   task automatic send_code_point(input logic [CP_W-1:0] cp, input logic eos);
      logic [7:0] seq[$];
      if (cp < MIN_TWO_BYTE) begin
         seq.push_back(cp[7:0]);
      end else if (cp < MIN_THREE_BYTE) begin
         seq.push_back({3'b110, cp[10:6]});
         seq.push_back({2'b10, cp[5:0]});
      end else if (cp < MIN_FOUR_BYTE) begin
         seq.push_back({4'b1110, cp[15:12]});
         seq.push_back({2'b10, cp[11:6]});
         seq.push_back({2'b10, cp[5:0]});
      end else begin
         seq.push_back({5'b11110, cp[20:18]});
         seq.push_back({2'b10, cp[17:12]});
         seq.push_back({2'b10, cp[11:6]});
         seq.push_back({2'b10, cp[5:0]});
      end
      send_sequence(seq, eos);
   endtask

   function automatic logic [CP_W-1:0] random_code_point();
      case ($urandom_range(3))
         0: return CP_W'($urandom_range(32'h7F));
         1: return CP_W'($urandom_range(32'h80, 32'h7FF));
         2: return CP_W'($urandom_range(32'h800, 32'hFFFF));
         default: return CP_W'($urandom_range(32'h10000, 32'h10FFFF));
      endcase
   endfunction

   // Holds the sender back until every predicted result has been taken.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_utf16_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_ascii_extremes();
      send_beat(8'h00, 1'b0);
      send_beat(8'h7F, 1'b1);
   endtask

   task automatic test_sequence_boundaries();
      send_code_point(21'h000080, 1'b0);
      send_code_point(21'h00FFFF, 1'b0);
      send_code_point(21'h00DFFF, 1'b0);
      send_code_point(21'h10FFFF, 1'b1);
   endtask

   task automatic test_malformed_input();
      // Truncated at the end of the string.
      send_beat(8'hE2, 1'b0);
      send_beat(8'h82, 1'b1);
      // Stray continuation as a lead; the following byte is dropped.
      send_beat(8'h80, 1'b0);
      send_beat(8'h41, 1'b1);
      // Sequence broken by a plain ASCII byte.
      send_beat(8'hC3, 1'b0);
      send_beat(8'h41, 1'b1);
      // Overlong two-byte form.
      send_beat(8'hC0, 1'b0);
      send_beat(8'hAF, 1'b1);
      // Four-byte form above the last code point.
      send_beat(8'hF4, 1'b0);
      send_beat(8'h90, 1'b0);
      send_beat(8'h80, 1'b0);
      send_beat(8'h80, 1'b1);
      send_beat(8'hF8, 1'b1);
   endtask

   task automatic test_unit_overflow();
      // The surrogate pair fills the last two units, so the next byte overflows.
      repeat (MAX_UNITS - 2) begin
         send_beat(8'($urandom_range(127)), 1'b0);
      end
      send_code_point(CP_W'($urandom_range(32'h10000, 32'h10FFFF)), 1'b0);
      send_beat(8'h41, 1'b0);
      send_beat(8'($urandom_range(255)), 1'b0);
      send_beat(8'($urandom_range(255)), 1'b1);
   endtask

   task automatic test_random_strings(input int unsigned beat_goal);
      int unsigned start;
      int unsigned n_chars;
      int unsigned n_cont;
      int unsigned pick;
      logic [7:0]  seq[$];
      logic [7:0]  lo;
      logic [7:0]  hi;
      bit          last_char;
      start = beats_sent;
      while (beats_sent - start < beat_goal) begin
         n_chars = $urandom_range(1, 10);
         for (int c = 0; c < n_chars; c++) begin
            last_char = (c == n_chars - 1);
            pick = $urandom_range(99);
            seq.delete();
            if (pick < 82) begin
               send_code_point(random_code_point(), last_char);
            end else begin
               if (pick < 88) begin
                  seq.push_back(8'($urandom_range(255)));
               end else if (pick < 94) begin
                  // Overlong, too large or illegal lead, with a plausible tail.
                  lo = 8'h80;
                  hi = 8'hBF;
                  case ($urandom_range(5))
                     0: begin
                        seq.push_back(8'($urandom_range(8'hC0, 8'hC1)));
                        n_cont = 1;
                     end
                     1: begin
                        seq.push_back(8'hE0);
                        hi = 8'h9F;
                        n_cont = 2;
                     end
                     2: begin
                        seq.push_back(8'hF0);
                        hi = 8'h8F;
                        n_cont = 3;
                     end
                     3: begin
                        seq.push_back(8'hF4);
                        lo = 8'h90;
                        n_cont = 3;
                     end
                     4: begin
                        seq.push_back(8'($urandom_range(8'hF5, 8'hF7)));
                        n_cont = 3;
                     end
                     default: begin
                        seq.push_back(8'($urandom_range(8'hF8, 8'hFF)));
                        n_cont = 1;
                     end
                  endcase
                  seq.push_back(8'($urandom_range(lo, hi)));
                  for (int k = 1; k < n_cont; k++) begin
                     seq.push_back(8'h80 | 8'($urandom_range(63)));
                  end
               end else begin
                  // A lead byte whose sequence is cut short.
                  n_cont = $urandom_range(1, 3);
                  case (n_cont)
                     1: seq.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                     2: seq.push_back(8'($urandom_range(8'hE1, 8'hEC)));
                     default: seq.push_back(8'($urandom_range(8'hF1, 8'hF3)));
                  endcase
                  repeat ($urandom_range(0, n_cont - 1)) begin
                     seq.push_back(8'h80 | 8'($urandom_range(63)));
                  end
               end
               send_sequence(seq, last_char);
            end
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 34;
      recv_idle_pct = 71;
      test_ascii_extremes();
      test_sequence_boundaries();
      test_malformed_input();
      test_unit_overflow();
      test_random_strings(15);
      drain_results();

      send_idle_pct = 71;
      recv_idle_pct = 34;
      test_random_strings(15);
      drain_results();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_strings(15);
      drain_results();

      if (mismatch_count == 0 && expected_utf16_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/u8u16_pkg.sv
rtl/utf8_to_utf16_transcoder_unit.sv
tb/sv/tb_utf8_to_utf16_transcoder_unit.sv
